@@ hw/rtl/bbfa_pkg.sv @@
// Shared constants of the bitmap best-fit allocator: widths, status codes, register indexes.
package bbfa_pkg;

  localparam int MAX_BYTES_DEF = 2048;

  localparam int SIZE_W   = 12;
  localparam int ADDR_W   = 16;
  localparam int STATUS_W = 3;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_SIZE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 1'd1;

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET = 12'd2048;

  localparam logic CMD_RESERVE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_OURS      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY         = 3'd4;

endpackage

@@ hw/rtl/bitmap_best_fit_allocator.sv @@
// Bitmap best-fit byte allocator: usage map sequencer, range check and result register.
//
//  Channel   Direction  Handshake                    Contents (lowest bit first)
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: command; tdata: block_size,
//                                                    block_address, zero pad to 32 bits
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: status, granted_address,
//                                                    zero pad to 24 bits
//  cfg       in         cfg_wen                      cfg_index selects the register,
//                                                    cfg_wdata carries its value
//
// After reset a clearing pass writes every usage bit to free, one bit a cycle, and the block
// takes no word until the pass is over; configuration writes are taken during the pass.
// A reserve of nonzero size reads the usage map through the single RAM read port, one bit a
// cycle, over the managed range, then marks its block at one bit a cycle. A release reads its
// bytes to check that all are held and then frees them. Zero-size requests and releases
// outside the range go straight to the result without touching the usage map.
// One word is worked on at a time; the result register lets the next word be accepted while
// a result still waits on m_axis_tready, and a finished result waits only if it is still full.
module bitmap_best_fit_allocator
  import bbfa_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // block_size[11:0], block_address[27:12]
  input  logic                   s_axis_tuser,   // command[0]
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // status[2:0], granted_address[18:3]
);

  localparam int AW    = $clog2(MAX_BYTES);
  localparam int LIM_W = $clog2(MAX_BYTES + 1);
  localparam int CMP_W = (LIM_W > SIZE_W) ? LIM_W : SIZE_W;
  localparam int RNG_W = ADDR_W + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state;

  logic [SIZE_W-1:0]   heap_size;
  logic [ADDR_W-1:0]   base_address;
  logic [SIZE_W-1:0]   last_size;

  logic [SIZE_W-1:0]   req_size;
  logic [LIM_W-1:0]    idx;
  logic [LIM_W-1:0]    pidx;
  logic                pvalid;
  logic [LIM_W-1:0]    run_start;
  logic [LIM_W-1:0]    run_len;
  logic                found;
  logic [LIM_W-1:0]    span_at;
  logic [LIM_W-1:0]    best_len;
  logic                bad;
  logic [LIM_W-1:0]    mark_idx;
  logic [SIZE_W-1:0]   mark_cnt;
  logic                fill_val;

  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_addr;

  logic [LIM_W-1:0]    limit;
  logic                better;
  logic [LIM_W-1:0]    place_at;
  logic                in_range;
  logic [LIM_W-1:0]    rel_off;

  logic                in_cmd;
  logic [SIZE_W-1:0]   in_size;
  logic [ADDR_W-1:0]   in_addr;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [0:0]          ram_wdata;
  logic [0:0]          ram_rdata;

  assign in_cmd  = s_axis_tuser;
  assign in_size = s_axis_tdata[SIZE_W-1:0];
  assign in_addr = s_axis_tdata[SIZE_W +: ADDR_W];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - STATUS_W - ADDR_W){1'b0}}, out_addr, out_status};

  // Heap sizes above the map's depth act as the full map.
  assign limit = (32'(heap_size) > MAX_BYTES) ? LIM_W'(MAX_BYTES) : LIM_W'(heap_size);

  // The one compare unit of the scan: a closed free run is taken when it fits and is
  // strictly shorter than the best so far, so the first of equal candidates wins.
  assign better = (CMP_W'(run_len) >= CMP_W'(req_size)) && (!found || (run_len < best_len));

  // A block smaller than the previous size goes at the right end of its span.
  assign place_at = (req_size < last_size)
                  ? LIM_W'(CMP_W'(span_at) + CMP_W'(best_len) - CMP_W'(req_size))
                  : span_at;

  // The release must lie wholly inside the managed range; sums are one bit wider, no wrap.
  assign in_range = (in_addr >= base_address) &&
                    ((RNG_W'(in_addr) + RNG_W'(in_size)) <=
                     (RNG_W'(base_address) + RNG_W'(limit)));
  assign rel_off  = LIM_W'(in_addr - base_address);

  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_FILL);
    ram_waddr = (state == S_CLEAR) ? idx[AW-1:0] : mark_idx[AW-1:0];
    ram_wdata = (state == S_FILL) ? fill_val : 1'b0;
  end

  bbfa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BYTES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      idx          <= '0;
      pvalid       <= 1'b0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
      heap_size    <= HEAP_SIZE_RESET;
      base_address <= '0;
      last_size    <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_HEAP_SIZE:    heap_size    <= cfg_wdata[SIZE_W-1:0];
          REG_BASE_ADDRESS: base_address <= cfg_wdata[ADDR_W-1:0];
          default:          ;
        endcase
      end

      // The result register fills from the finished word and empties when taken.
      if ((state == S_DONE) && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == LIM_W'(MAX_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_size <= in_size;
            res_addr <= '0;
            pvalid   <= 1'b0;
            if (in_cmd == CMD_RESERVE) begin
              if (in_size == '0) begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end else begin
                idx       <= '0;
                run_start <= '0;
                run_len   <= '0;
                found     <= 1'b0;
                state     <= S_SCAN;
              end
            end else begin
              if (in_size == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                last_size <= in_size;
                if (!in_range) begin
                  res_status <= ST_NOT_OURS;
                  state      <= S_DONE;
                end else begin
                  idx      <= rel_off;
                  span_at  <= rel_off;
                  mark_cnt <= in_size;
                  bad      <= 1'b0;
                  state    <= S_CHECK;
                end
              end
            end
          end
        end

        S_SCAN: begin
          if (idx < limit) begin
            idx    <= idx + 1'b1;
            pidx   <= idx;
            pvalid <= 1'b1;
          end else begin
            pvalid <= 1'b0;
          end
          if (pvalid) begin
            if (!ram_rdata[0]) begin
              run_len <= run_len + 1'b1;
            end else begin
              if (better) begin
                span_at  <= run_start;
                best_len <= run_len;
                found    <= 1'b1;
              end
              run_start <= pidx + 1'b1;
              run_len   <= '0;
            end
          end else if (idx == limit) begin
            if (better) begin
              span_at  <= run_start;
              best_len <= run_len;
              found    <= 1'b1;
            end
            state <= S_PLACE;
          end
        end

        S_PLACE: begin
          if (!found) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            last_size  <= req_size;
            mark_idx   <= place_at;
            mark_cnt   <= req_size;
            fill_val   <= 1'b1;
            res_status <= ST_OK;
            res_addr   <= base_address + ADDR_W'(place_at);
            state      <= S_FILL;
          end
        end

        S_FILL: begin
          mark_idx <= mark_idx + 1'b1;
          mark_cnt <= mark_cnt - 1'b1;
          if (mark_cnt == SIZE_W'(1)) begin
            state <= S_DONE;
          end
        end

        S_CHECK: begin
          if (mark_cnt != '0) begin
            idx      <= idx + 1'b1;
            mark_cnt <= mark_cnt - 1'b1;
            pvalid   <= 1'b1;
          end else begin
            pvalid <= 1'b0;
          end
          if (pvalid && !ram_rdata[0]) begin
            bad <= 1'b1;
          end
          if ((mark_cnt == '0) && !pvalid) begin
            if (bad) begin
              res_status <= ST_NOT_ALLOCATED;
              state      <= S_DONE;
            end else begin
              mark_idx   <= span_at;
              mark_cnt   <= req_size;
              fill_val   <= 1'b0;
              res_status <= ST_OK;
              state      <= S_FILL;
            end
          end
        end

        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_status <= res_status;
            out_addr   <= res_addr;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Marking and freeing never touch a byte beyond the managed range.
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (32'(mark_idx) < 32'(limit)))
    else $error("usage map write beyond the managed range");

  // A waiting result is never overwritten by the next one.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_valid && !m_axis_tready) |=> (state == S_DONE))
    else $error("result register overwritten while full");

  // A failed reserve leaves the previous size untouched.
  a_no_space_keeps_size: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PLACE) && !found) |=> $stable(last_size))
    else $error("last size changed by a reserve without space");

  // Only a successful reserve carries an address.
  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> (out_addr == '0))
    else $error("address given with a failure status");

endmodule

@@ hw/rtl/bbfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bbfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ dv/bbfa_checker.sv @@
`timescale 1ns / 100ps
// Checker of the bitmap best-fit allocator: watches the channels, predicts each result, compares.
module bbfa_checker
  import bbfa_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int unsigned            mismatches,
  output int unsigned            pending
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted;
  } alloc_result_t;

  bit                usage_map [MAX_BYTES];
  logic [SIZE_W-1:0] last_size;
  logic [SIZE_W-1:0] heap_size;
  logic [ADDR_W-1:0] base_address;
  alloc_result_t     grant_q[$];
  int unsigned       errs = 0;

  // Applies one request to the shadow map and returns the result it must produce.
  function automatic alloc_result_t serve_request(input logic cmd,
                                                  input logic [SIZE_W-1:0] nbytes,
                                                  input logic [ADDR_W-1:0] addr);
    alloc_result_t res;
    int  limit, cur, nb, span, best_at, best_left, best_len, at, offs;
    bit  found;
    res.status  = ST_OK;
    res.granted = '0;
    limit = (int'(heap_size) > MAX_BYTES) ? MAX_BYTES : int'(heap_size);
    if (cmd == CMD_RESERVE) begin
      if (nbytes == 0) return res;
      found     = 1'b0;
      cur       = 0;
      best_at   = 0;
      best_left = 0;
      best_len  = 0;
      do begin
        nb = cur;
        while (nb < limit && !usage_map[nb]) nb++;
        span = nb - cur;
        if (span >= int'(nbytes)) begin
          if (!found || span - int'(nbytes) < best_left) begin
            found     = 1'b1;
            best_at   = cur;
            best_left = span - int'(nbytes);
            best_len  = span;
          end
        end
        cur = nb + 1;
      end while (cur < limit);
      if (!found) begin
        res.status = ST_NO_SPACE;
        return res;
      end
      // Smaller than the previous size: pack against the right end of the span.
      at = (nbytes < last_size) ? best_at + best_len - int'(nbytes) : best_at;
      last_size = nbytes;
      for (int i = 0; i < int'(nbytes); i++) usage_map[at + i] = 1'b1;
      res.granted = ADDR_W'(int'(base_address) + at);
      return res;
    end
    if (nbytes == 0) begin
      res.status = ST_EMPTY;
      return res;
    end
    last_size = nbytes;
    if (addr < base_address ||
        int'(addr) + int'(nbytes) > int'(base_address) + limit) begin
      res.status = ST_NOT_OURS;
      return res;
    end
    offs = int'(addr) - int'(base_address);
    for (int i = 0; i < int'(nbytes); i++) begin
      if (!usage_map[offs + i]) begin
        res.status = ST_NOT_ALLOCATED;
        return res;
      end
    end
    for (int i = 0; i < int'(nbytes); i++) usage_map[offs + i] = 1'b0;
    return res;
  endfunction

  task automatic log_mismatch(input string why, input logic [STATUS_W-1:0] want_status,
                              input logic [ADDR_W-1:0] want_addr,
                              input logic [STATUS_W-1:0] got_status,
                              input logic [ADDR_W-1:0] got_addr);
    errs++;
    if (errs <= 10)
      $display("%0t: %s: expected status %0d address %h, got status %0d address %h",
               $time, why, want_status, want_addr, got_status, got_addr);
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t       want;
    logic [STATUS_W-1:0] got_status;
    logic [ADDR_W-1:0]   got_addr;
    if (rst) begin
      foreach (usage_map[i]) usage_map[i] = 1'b0;
      last_size    = '0;
      heap_size    = HEAP_SIZE_RESET;
      base_address = '0;
      grant_q.delete();
    end else begin
      // The oldest result leaves before a word accepted at the same edge is predicted.
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = m_axis_tdata[STATUS_W-1:0];
        got_addr   = m_axis_tdata[STATUS_W +: ADDR_W];
        if (grant_q.size() == 0) begin
          log_mismatch("result with nothing outstanding", '0, '0, got_status, got_addr);
        end else begin
          want = grant_q.pop_front();
          if (want.status != got_status || want.granted != got_addr)
            log_mismatch("wrong result", want.status, want.granted, got_status, got_addr);
        end
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_HEAP_SIZE: heap_size = cfg_wdata[SIZE_W-1:0];
          REG_BASE_ADDRESS: base_address = cfg_wdata[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        grant_q.push_back(serve_request(s_axis_tuser, s_axis_tdata[SIZE_W-1:0],
                                        s_axis_tdata[SIZE_W +: ADDR_W]));
    end
    pending    <= grant_q.size();
    mismatches <= errs;
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request and result traffic, and the verdict.
module testbench;
  import bbfa_pkg::*;

  // The slowest correct run stays well below the limit: most phases use small heaps, and only
  // two phases scan the full map of 2048 bytes per reserve.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  // Length of the one long hold-off on the result side.
  localparam int unsigned HOLD_CYCLES = 400;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_wen       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = REG_HEAP_SIZE;
  logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = CMD_RESERVE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;

  // Traffic shaping: steady switches idling off on both sides, hold_req asks the result side
  // for its single long hold-off.
  bit          steady    = 1'b0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Stimulus bookkeeping only: the current window and the blocks known to be reserved, so
  // that most releases name a real block. Prediction lives entirely in the checker.
  int                active_bytes = MAX_BYTES_DEF;
  int                cur_base     = 0;
  logic [SIZE_W:0]   req_log[$];
  logic [ADDR_W-1:0] live_addr[$];
  logic [SIZE_W-1:0] live_size[$];

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  bitmap_best_fit_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bbfa_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatch_count),
    .pending       (pending_count)
  );

  // Result side. It drops tready at random, with odds of 11 in a hundred, never while steady is set,
  // and once holds off for HOLD_CYCLES so that the block fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 11);
    end
  end

  // Pairs each result with the request word it answers and keeps a list of granted blocks.
  // The pop comes first, so a word accepted at the same edge is never matched too early.
  always @(posedge clk) begin : track
    logic [SIZE_W:0] req;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready && req_log.size() != 0) begin
        req = req_log.pop_front();
        if (req[SIZE_W] == CMD_RESERVE && req[SIZE_W-1:0] != 0 &&
            m_axis_tdata[STATUS_W-1:0] == ST_OK) begin
          live_addr.push_back(m_axis_tdata[STATUS_W +: ADDR_W]);
          live_size.push_back(req[SIZE_W-1:0]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        req_log.push_back({s_axis_tuser, s_axis_tdata[SIZE_W-1:0]});
    end
  end

  // Offers one request word, idling first at random, and returns just after the edge at
  // which it was taken. tvalid stays high so that a following word runs on without a gap.
  task automatic send_word(input logic cmd, input logic [SIZE_W-1:0] nbytes,
                           input logic [ADDR_W-1:0] addr);
    while (!steady && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0000, addr, nbytes};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Lowers tvalid and waits until every outstanding result has been taken. Each word gives
  // exactly one result, so an empty checker queue means the block has gone idle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; called only while no word is outstanding.
  task automatic write_regs(input logic [CFG_DATA_W-1:0] heap_word,
                            input logic [CFG_DATA_W-1:0] base);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_HEAP_SIZE;
    cfg_wdata <= heap_word;
    @(posedge clk);
    cfg_index <= REG_BASE_ADDRESS;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_wen <= 1'b0;
    active_bytes = (int'(heap_word[SIZE_W-1:0]) > MAX_BYTES_DEF) ?
                   MAX_BYTES_DEF : int'(heap_word[SIZE_W-1:0]);
    cur_base = int'(base);
  endtask

  // One setting of the registers: the whole window taken and given back, then random traffic,
  // then every block still held is released so the next setting starts from a clean map.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] heap_word,
                           input logic [CFG_DATA_W-1:0] base, input int n_items,
                           input bit quiet, input bit squeeze);
    int                r;
    int                idx;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] ad;
    write_regs(heap_word, base);
    steady <= quiet;
    send_word(CMD_RESERVE, SIZE_W'(active_bytes), ADDR_W'($urandom));
    send_word(CMD_RELEASE, SIZE_W'(active_bytes), base);
    for (int k = 0; k < n_items; k++) begin
      if (squeeze && k == 10) hold_req <= 1'b1;
      r = $urandom_range(99);
      if (live_addr.size() != 0 && r < 40) begin
        // Release of a real block; now and then it is damaged, and the block is kept for a later release.
        idx = $urandom_range(live_addr.size() - 1);
        ad  = live_addr[idx];
        sz  = live_size[idx];
        if ($urandom_range(11) == 0) begin
          if ($urandom_range(1) != 0) sz = sz + 1'b1;
          else ad = ad + 1'b1;
        end else begin
          live_addr.delete(idx);
          live_size.delete(idx);
        end
        send_word(CMD_RELEASE, sz, ad);
      end else if (r < 80) begin
        case ($urandom_range(9))
          0: sz = '0;
          1: sz = ($urandom_range(1) != 0) ? SIZE_W'($urandom_range(4095)) :
                                             SIZE_W'($urandom_range(active_bytes + 4));
          default: sz = SIZE_W'($urandom_range(1, active_bytes > 7 ? active_bytes / 4 : 2));
        endcase
        send_word(CMD_RESERVE, sz, ADDR_W'($urandom));
      end else begin
        // Noise: releases near or inside the window, mostly of bytes that are not held.
        ad = ($urandom_range(7) == 0) ? ADDR_W'($urandom) :
             ADDR_W'(cur_base + $urandom_range(active_bytes) - $urandom_range(1));
        sz = ($urandom_range(7) == 0) ? SIZE_W'($urandom_range(4095)) :
             SIZE_W'($urandom_range(6));
        send_word(CMD_RELEASE, sz, ad);
      end
    end
    wait_idle();
    while (live_addr.size() != 0) begin
      ad = live_addr.pop_front();
      sz = live_size.pop_front();
      send_word(CMD_RELEASE, sz, ad);
    end
    wait_idle();
  endtask

  // Watchdog on the cycle counter.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a 16-byte window at 0x0100. The block is still running its clearing
    // pass here; the register writes are taken during it and the first word simply waits.
    write_regs(16'h0010, 16'h0100);
    send_word(CMD_RESERVE, 12'd0, 16'hFFFF);     // zero-size reserve
    send_word(CMD_RELEASE, 12'd0, 16'hFFFF);     // zero-size release
    send_word(CMD_RESERVE, 12'd4, 16'h0000);     // left end, last size still zero
    send_word(CMD_RESERVE, 12'd2, 16'h0000);     // smaller than last: right end of the span
    send_word(CMD_RESERVE, 12'hFFF, 16'h0000);   // far too large
    send_word(CMD_RESERVE, 12'd2048, 16'h0000);  // larger than the window
    send_word(CMD_RESERVE, 12'd10, 16'h0000);    // exact fit in the middle
    send_word(CMD_RESERVE, 12'd1, 16'h0000);     // map full: no space
    send_word(CMD_RELEASE, 12'd10, 16'h0104);
    send_word(CMD_RELEASE, 12'd10, 16'h0104);    // same again: not allocated
    send_word(CMD_RELEASE, 12'd1, 16'h00FF);     // below the base
    send_word(CMD_RELEASE, 12'd3, 16'h010E);     // runs past the window end
    send_word(CMD_RELEASE, 12'hFFF, 16'h0000);   // huge release, outside
    send_word(CMD_RELEASE, 12'd2, 16'h010E);
    send_word(CMD_RESERVE, 12'd3, 16'h0000);
    send_word(CMD_RESERVE, 12'd5, 16'h0000);
    send_word(CMD_RELEASE, 12'd4, 16'h0100);
    send_word(CMD_RELEASE, 12'd3, 16'h0104);
    send_word(CMD_RELEASE, 12'd5, 16'h0107);
    send_word(CMD_RESERVE, 12'd16, 16'h0000);    // the whole window
    send_word(CMD_RELEASE, 12'd16, 16'h0100);
    wait_idle();

    // Random part over several settings; the upper nibble of the heap word is don't-care.
    run_phase({4'($urandom), 12'd64}, 16'($urandom_range(16'hF000)), 60, 1'b0, 1'b1);
    run_phase({4'($urandom), 12'd1}, 16'hFFFF, 20, 1'b0, 1'b0);
    run_phase({4'($urandom), 12'd0}, 16'($urandom), 8, 1'b0, 1'b0);
    run_phase({4'($urandom), 12'd200}, 16'($urandom_range(16'hF000)), 70, 1'b1, 1'b0);
    run_phase({4'($urandom), 12'hFFF}, 16'h0000, 15, 1'b0, 1'b0);
    run_phase({4'($urandom), 12'd2048}, 16'($urandom_range(16'hF000)), 12, 1'b0, 1'b0);
    // Last, since grants that wrap past 0xFFFF cannot be released and stay held.
    run_phase({4'($urandom), 12'd100}, 16'hFFC0, 50, 1'b0, 1'b0);

    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
